/* rtl/scba_pkg.sv */
`timescale 1ns / 1ps
package scba_pkg;

	localparam int STORE_WORDS  = 4096;
	localparam int SIZE_CLASSES = 256;

	localparam int ADDR_W  = $clog2(STORE_WORDS);
	localparam int LINK_W  = ADDR_W + 1;
	localparam int CLS_W   = $clog2(SIZE_CLASSES);
	localparam int SIZE_W  = 9;
	localparam int RWORD_W = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam logic [LINK_W-1:0] HEAD_EMPTY = LINK_W'(STORE_WORDS);

	localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_REGION_WORDS = CFG_IDX_W'(1);

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	localparam logic ST_OK        = 1'b0;
	localparam logic ST_EXHAUSTED = 1'b1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_POP
	} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic finish_err;
		logic finish_free;
		logic finish_bump;
		logic pop_read;
		logic finish_pop;
	} dp_cmd_t;

	typedef struct packed {
		logic size_ok;
		logic is_free;
		logic head_empty;
		logic out_free;
	} dp_status_t;

endpackage

/* rtl/scba_ram.sv */
`timescale 1ns / 1ps
module scba_ram #(
	parameter int WIDTH = 13,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* rtl/scba_ctrl.sv */
`timescale 1ns / 1ps
module scba_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  scba_pkg::dp_status_t sts,
	output scba_pkg::dp_cmd_t    cmd
);
	import scba_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_LOOK;
				end
			end
			S_LOOK: begin
				// head table data is held until the result slot frees up
				if (sts.out_free) begin
					priority if (!sts.size_ok) begin
						cmd.finish_err = 1'b1;
						state_d        = S_IDLE;
					end else if (sts.is_free) begin
						cmd.finish_free = 1'b1;
						state_d         = S_IDLE;
					end else if (!sts.head_empty) begin
						cmd.pop_read = 1'b1;
						state_d      = S_POP;
					end else begin
						cmd.finish_bump = 1'b1;
						state_d         = S_IDLE;
					end
				end
			end
			S_POP: begin
				if (sts.out_free) begin
					cmd.finish_pop = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* rtl/scba_dp.sv */
`timescale 1ns / 1ps
module scba_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  scba_pkg::dp_cmd_t               cmd,
	output scba_pkg::dp_status_t            sts,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [scba_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [scba_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            func,
	input  logic [scba_pkg::SIZE_W-1:0]     block_size,
	input  logic [scba_pkg::ADDR_W-1:0]     free_start,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [scba_pkg::ADDR_W-1:0]     granted_start,
	output logic [scba_pkg::SIZE_W-1:0]     granted_size,
	output logic                            status
);
	import scba_pkg::*;

	logic [ADDR_W-1:0]  region_base_q;
	logic [RWORD_W-1:0] region_words_q;
	logic [RWORD_W-1:0] words_used_q;
	logic [SIZE_CLASSES-1:0] head_vld_q;

	logic               func_q;
	logic [SIZE_W-1:0]  size_q;
	logic [ADDR_W-1:0]  free_start_q;
	logic               head_vld_s1;

	logic               out_valid_q;
	logic [ADDR_W-1:0]  granted_start_q;
	logic [SIZE_W-1:0]  granted_size_q;
	logic               status_q;

	logic [CLS_W-1:0]   in_cls;
	logic [CLS_W-1:0]   cls;
	logic [LINK_W-1:0]  head_rd;
	logic [LINK_W-1:0]  head_eff;
	logic [LINK_W-1:0]  link_rd;
	logic [LINK_W-1:0]  next_head;
	logic [RWORD_W:0]   bump_sum;
	logic               bump_fits;
	logic [ADDR_W-1:0]  bump_addr;

	logic               head_we;
	logic [LINK_W-1:0]  head_wdata;
	logic               finish;

	assign in_cls    = CLS_W'(block_size - SIZE_W'(1));
	assign cls       = CLS_W'(size_q - SIZE_W'(1));
	assign head_eff  = head_vld_s1 ? head_rd : HEAD_EMPTY;
	assign next_head = link_rd[ADDR_W] ? HEAD_EMPTY : link_rd;

	assign bump_sum  = {1'b0, words_used_q} + (RWORD_W + 1)'(size_q);
	assign bump_fits = bump_sum <= {1'b0, region_words_q};
	assign bump_addr = region_base_q + words_used_q[ADDR_W-1:0];

	assign head_we    = cmd.finish_free | cmd.finish_pop;
	assign head_wdata = cmd.finish_free ? {1'b0, free_start_q} : next_head;
	assign finish     = cmd.finish_err | cmd.finish_free | cmd.finish_bump | cmd.finish_pop;

	assign sts.size_ok    = (size_q != '0) && (size_q <= SIZE_W'(SIZE_CLASSES));
	assign sts.is_free    = (func_q == FUNC_FREE);
	assign sts.head_empty = head_eff[ADDR_W];
	assign sts.out_free   = !out_valid_q || out_ready;

	assign cfg_ready     = 1'b1;
	assign out_valid     = out_valid_q;
	assign granted_start = granted_start_q;
	assign granted_size  = granted_size_q;
	assign status        = status_q;

	scba_ram #(.WIDTH(LINK_W), .DEPTH(SIZE_CLASSES)) u_heads (
		.clk     (clk),
		.wr_en   (head_we),
		.wr_addr (cls),
		.wr_data (head_wdata),
		.rd_en   (cmd.capture),
		.rd_addr (in_cls),
		.rd_data (head_rd)
	);

	// link of a freed block lives at its first word
	scba_ram #(.WIDTH(LINK_W), .DEPTH(STORE_WORDS)) u_links (
		.clk     (clk),
		.wr_en   (cmd.finish_free),
		.wr_addr (free_start_q),
		.wr_data (head_eff),
		.rd_en   (cmd.pop_read),
		.rd_addr (head_eff[ADDR_W-1:0]),
		.rd_data (link_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_base_q  <= '0;
			region_words_q <= RWORD_W'(STORE_WORDS);
			words_used_q   <= '0;
			head_vld_q     <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == REG_REGION_BASE) begin
					region_base_q <= cfg_data[ADDR_W-1:0];
				end else if (cfg_index == REG_REGION_WORDS) begin
					region_words_q <= cfg_data[RWORD_W-1:0];
				end
			end
			if (cmd.finish_bump && bump_fits) begin
				words_used_q <= bump_sum[RWORD_W-1:0];
			end
			if (head_we) begin
				head_vld_q[cls] <= 1'b1;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q       <= func;
			size_q       <= block_size;
			free_start_q <= free_start;
			head_vld_s1  <= head_vld_q[in_cls];
		end
		if (finish) begin
			granted_size_q <= size_q;
			priority if (cmd.finish_pop) begin
				granted_start_q <= head_eff[ADDR_W-1:0];
				status_q        <= ST_OK;
			end else if (cmd.finish_bump && bump_fits) begin
				granted_start_q <= bump_addr;
				status_q        <= ST_OK;
			end else if (cmd.finish_free) begin
				granted_start_q <= '0;
				status_q        <= ST_OK;
			end else begin
				granted_start_q <= '0;
				status_q        <= ST_EXHAUSTED;
			end
		end
	end

endmodule

/* rtl/size_class_block_allocator_core.sv */
`timescale 1ns / 1ps
// Size-class block allocator: one LIFO free list per block size (1 to 256 words) with a
// bump pointer over the configured region as fallback. A request first does a registered
// read of the list head table, and a pop from a free list adds a registered read of the
// link memory. A free, a bump carve, a refused request or a pop then finishes, and the
// result is written to an output register that
// holds it until taken while the next request is already accepted. List heads are empty
// right after reset through per-class valid bits, so there is no clearing pass. Config
// writes are taken every cycle and should only be issued while no request is in flight.
module size_class_block_allocator_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [scba_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [scba_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            func,
	input  logic [scba_pkg::SIZE_W-1:0]     block_size,
	input  logic [scba_pkg::ADDR_W-1:0]     free_start,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [scba_pkg::ADDR_W-1:0]     granted_start,
	output logic [scba_pkg::SIZE_W-1:0]     granted_size,
	output logic                            status
);
	import scba_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t sts;

	scba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	scba_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.func          (func),
		.block_size    (block_size),
		.free_start    (free_start),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.granted_start (granted_start),
		.granted_size  (granted_size),
		.status        (status)
	);

	// the controller is never ready in the cycle after it accepts a request
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted on consecutive cycles");

	// a new result only comes from a request in flight
	a_result_from_request: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared with no request in flight");

	// a refused request never grants an address
	a_refused_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_EXHAUSTED) |-> (granted_start == '0))
		else $error("refused request carries a start address");

	// the controller never issues two commands at once
	a_single_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("conflicting datapath commands");

endmodule

/* test/size_class_block_allocator_core_tb.sv */
`timescale 1ns / 1ps
module size_class_block_allocator_core_tb;
	import scba_pkg::*;

	typedef struct {
		logic              func;
		logic [SIZE_W-1:0] block_size;
		logic [ADDR_W-1:0] free_start;
	} request_t;

	typedef struct {
		logic [ADDR_W-1:0] start;
		logic [SIZE_W-1:0] size;
		logic              status;
	} grant_t;

	typedef struct {
		logic [ADDR_W-1:0] start;
		logic [SIZE_W-1:0] size;
	} block_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_REGION_BASE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  func = FUNC_ALLOC;
	logic [SIZE_W-1:0]     block_size = '0;
	logic [ADDR_W-1:0]     free_start = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [ADDR_W-1:0]     granted_start;
	logic [SIZE_W-1:0]     granted_size;
	logic                  status;

	// predicted allocator state
	logic [LINK_W-1:0]  list_head[SIZE_CLASSES];
	logic [LINK_W-1:0]  link_word[STORE_WORDS];
	logic [RWORD_W-1:0] bump_used;
	logic [ADDR_W-1:0]  base_reg;
	logic [RWORD_W-1:0] words_reg;

	request_t pending_requests[$];
	grant_t   expected_grants[$];
	block_t   live_blocks[$];

	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit sender_hold = 1'b0;

	size_class_block_allocator_core i_dut (.*);

	always #5 clk = ~clk;

	initial begin
		#2_000_000;
		$display("size_class_block_allocator_core_tb failed");
		$finish;
	end

	function automatic grant_t grant_for(input request_t r);
		grant_t g;
		int cls;
		logic [LINK_W-1:0] blk;
		logic [LINK_W-1:0] nxt;
		g.start = '0;
		g.size = r.block_size;
		g.status = ST_OK;
		if (r.block_size == 0 || r.block_size > SIZE_CLASSES) begin
			g.status = ST_EXHAUSTED;
			return g;
		end
		cls = r.block_size - 1;
		if (r.func == FUNC_FREE) begin
			link_word[r.free_start] = list_head[cls];
			list_head[cls] = {1'b0, r.free_start};
			return g;
		end
		if (list_head[cls] < STORE_WORDS) begin
			blk = list_head[cls];
			nxt = link_word[blk[ADDR_W-1:0]];
			list_head[cls] = (nxt < STORE_WORDS) ? nxt : HEAD_EMPTY;
			g.start = blk[ADDR_W-1:0];
			return g;
		end
		if (int'(bump_used) + int'(r.block_size) > int'(words_reg)) begin
			g.status = ST_EXHAUSTED;
			return g;
		end
		// carved address wraps around the store
		g.start = ADDR_W'(int'(base_reg) + int'(bump_used));
		bump_used = bump_used + RWORD_W'(r.block_size);
		return g;
	endfunction

	task automatic flag(input string field, input int want, input int got);
		if (errors < 10)
			$display("mismatch %s: expected %0d, got %0d", field, want, got);
		errors++;
	endtask

	// check results first, then predict the request taken at the same edge
	always @(posedge clk or negedge arst_n) begin : check_grants
		grant_t want;
		request_t r;
		if (!arst_n) begin
			for (int i = 0; i < SIZE_CLASSES; i++)
				list_head[i] = HEAD_EMPTY;
			bump_used = '0;
			base_reg = '0;
			words_reg = RWORD_W'(STORE_WORDS);
			expected_grants.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_REGION_BASE: base_reg = cfg_data[ADDR_W-1:0];
					REG_REGION_WORDS: words_reg = cfg_data[RWORD_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_grants.size() == 0) begin
					flag("unexpected result, granted_start", -1, int'(granted_start));
				end else begin
					want = expected_grants.pop_front();
					if (granted_start !== want.start)
						flag("granted_start", int'(want.start), int'(granted_start));
					if (granted_size !== want.size)
						flag("granted_size", int'(want.size), int'(granted_size));
					if (status !== want.status)
						flag("status", int'(want.status), int'(status));
				end
			end
			if (in_valid && in_ready) begin
				r.func = func;
				r.block_size = block_size;
				r.free_start = free_start;
				want = grant_for(r);
				expected_grants.push_back(want);
				if (r.func == FUNC_ALLOC && want.status == ST_OK)
					live_blocks.push_back('{start: want.start, size: want.size});
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : drive_requests
		request_t r;
		if (!arst_n) begin
			in_valid <= 1'b0;
			func <= FUNC_ALLOC;
			block_size <= '0;
			free_start <= '0;
		end else if (!in_valid || in_ready) begin
			if (pending_requests.size() != 0 && !sender_hold &&
					$urandom_range(99) >= send_idle_pct) begin
				r = pending_requests.pop_front();
				in_valid <= 1'b1;
				func <= r.func;
				block_size <= r.block_size;
				free_start <= r.free_start;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic queue_request(input logic f, input int size, input int start);
		pending_requests.push_back('{func: f, block_size: SIZE_W'(size),
			free_start: ADDR_W'(start)});
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_requests.size() != 0 || in_valid || expected_grants.size() != 0);
		repeat (6) @(negedge clk);
	endtask

	initial begin
		request_t r;
		block_t b;
		int k;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 7;
		recv_stall_pct = 57;

		// empty region at the top of the store
		write_reg(REG_REGION_BASE, 4095);
		write_reg(REG_REGION_WORDS, 0);
		queue_request(FUNC_ALLOC, 1, 0);
		queue_request(FUNC_ALLOC, 0, 4095);
		queue_request(FUNC_FREE, 0, 4095);
		queue_request(FUNC_ALLOC, 511, 0);
		queue_request(FUNC_FREE, 257, 0);
		queue_request(FUNC_FREE, 256, 4095);
		queue_request(FUNC_ALLOC, 256, 0);
		queue_request(FUNC_ALLOC, 256, 0);
		wait_drained();

		// carve across the end of the store, then a double free
		write_reg(REG_REGION_WORDS, 4096);
		queue_request(FUNC_ALLOC, 1, 0);
		queue_request(FUNC_ALLOC, 2, 0);
		queue_request(FUNC_FREE, 2, 0);
		queue_request(FUNC_FREE, 255, 2048);
		queue_request(FUNC_FREE, 255, 2048);
		queue_request(FUNC_ALLOC, 255, 0);
		queue_request(FUNC_ALLOC, 255, 0);
		queue_request(FUNC_ALLOC, 2, 0);
		queue_request(FUNC_FREE, 1, 4095);
		queue_request(FUNC_ALLOC, 1, 0);
		wait_drained();
		live_blocks.delete();

		for (int part = 0; part < 3; part++) begin
			case (part)
				0: begin
					send_idle_pct = 7;
					recv_stall_pct = 57;
					write_reg(REG_REGION_BASE, $urandom_range(4095));
					write_reg(REG_REGION_WORDS, 4096);
				end
				1: begin
					send_idle_pct = 57;
					recv_stall_pct = 7;
					write_reg(REG_REGION_BASE, $urandom_range(4095));
					write_reg(REG_REGION_WORDS, $urandom_range(4096));
				end
				default: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
					write_reg(REG_REGION_BASE, 0);
					write_reg(REG_REGION_WORDS, 4096);
				end
			endcase
			for (int n = 0; n < 360; n++) begin
				if (part == 2 && n == 180) begin
					// hold off new requests until the block has answered everything
					sender_hold = 1'b1;
					do @(negedge clk); while (in_valid || expected_grants.size() != 0);
					sender_hold = 1'b0;
				end
				// keep the request queue short so frees follow the grants seen so far
				while (pending_requests.size() >= 3)
					@(negedge clk);
				if ($urandom_range(99) < 12) begin
					r.func = 1'($urandom_range(1));
					r.block_size = SIZE_W'($urandom_range(511));
					r.free_start = ADDR_W'($urandom_range(4095));
				end else if (live_blocks.size() == 0 ||
						(live_blocks.size() < 40 && $urandom_range(99) < 55)) begin
					r.func = FUNC_ALLOC;
					r.block_size = ($urandom_range(99) < 85) ? SIZE_W'($urandom_range(16, 1))
						: SIZE_W'($urandom_range(256, 17));
					r.free_start = ADDR_W'($urandom_range(4095));
				end else begin
					k = $urandom_range(live_blocks.size() - 1);
					b = live_blocks[k];
					live_blocks.delete(k);
					r.func = FUNC_FREE;
					r.block_size = b.size;
					r.free_start = b.start;
				end
				pending_requests.push_back(r);
			end
			wait_drained();
		end

		if (errors == 0 && expected_grants.size() == 0)
			$display("size_class_block_allocator_core_tb passed");
		else
			$display("size_class_block_allocator_core_tb failed");
		$finish;
	end

endmodule

/* size_class_block_allocator_core.f */
rtl/scba_pkg.sv
rtl/scba_ram.sv
rtl/scba_ctrl.sv
rtl/scba_dp.sv
rtl/size_class_block_allocator_core.sv
test/size_class_block_allocator_core_tb.sv
